### hdl/bmvs_pkg.sv
// Shared types, constants and parameter defaults for the brick-map voxel store.
package bmvs_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int COORD_W    = 7;
  localparam int KIND_W     = 8;
  localparam int SLOT_OUT_W = 8;

  // Access codes carried in the action field of a request.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Default geometry of the store.
  localparam int DEF_BRICK_EDGE    = 8;
  localparam int DEF_GRID_BRICKS_X = 16;
  localparam int DEF_GRID_BRICKS_Y = 16;
  localparam int DEF_GRID_BRICKS_Z = 16;
  localparam int DEF_POOL_BRICKS   = 256;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_POOL,
    ST_FILL,
    ST_FINISH
  } bmvs_state_t;

  // Commands to the shared pool address unit.
  typedef struct packed {
    logic load;
    logic step;
  } bmvs_addr_cmd_t;

endpackage

### hdl/bmvs_in_if.sv
// Request channel interface: one voxel access per transaction.
interface bmvs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [bmvs_pkg::COORD_W-1:0]  pos_x;
  logic [bmvs_pkg::COORD_W-1:0]  pos_y;
  logic [bmvs_pkg::COORD_W-1:0]  pos_z;
  logic [bmvs_pkg::KIND_W-1:0]   block_kind;

  modport source (output valid, action, pos_x, pos_y, pos_z, block_kind, input ready);
  modport sink   (input valid, action, pos_x, pos_y, pos_z, block_kind, output ready);
endinterface

### hdl/bmvs_out_if.sv
// Response channel interface: one result per transaction.
interface bmvs_out_if;
  logic                            valid;
  logic                            ready;
  logic [bmvs_pkg::KIND_W-1:0]     voxel_value;
  logic                            brick_was_uniform;
  logic [bmvs_pkg::SLOT_OUT_W-1:0] brick_slot;
  logic                            pool_full;

  modport source (output valid, voxel_value, brick_was_uniform, brick_slot, pool_full,
                  input ready);
  modport sink   (input valid, voxel_value, brick_was_uniform, brick_slot, pool_full,
                  output ready);
endinterface

### hdl/bmvs_coord_decode.sv
// Splits a voxel position into a brick index and an offset within the brick.
module bmvs_coord_decode #(
  parameter int BRICK_EDGE    = bmvs_pkg::DEF_BRICK_EDGE,
  parameter int GRID_BRICKS_X = bmvs_pkg::DEF_GRID_BRICKS_X,
  parameter int GRID_BRICKS_Y = bmvs_pkg::DEF_GRID_BRICKS_Y,
  parameter int GRID_BRICKS_Z = bmvs_pkg::DEF_GRID_BRICKS_Z,
  localparam int BRICK_COUNT  = GRID_BRICKS_X * GRID_BRICKS_Y * GRID_BRICKS_Z,
  localparam int BI_W         = (BRICK_COUNT > 1) ? $clog2(BRICK_COUNT) : 1,
  localparam int BRICK_VOXELS = BRICK_EDGE * BRICK_EDGE * BRICK_EDGE,
  localparam int VOX_W        = $clog2(BRICK_VOXELS)
) (
  input  logic [bmvs_pkg::COORD_W-1:0] pos_x,
  input  logic [bmvs_pkg::COORD_W-1:0] pos_y,
  input  logic [bmvs_pkg::COORD_W-1:0] pos_z,
  output logic [BI_W-1:0]              brick_idx,
  output logic [VOX_W-1:0]             local_idx,
  output logic                         outside
);

  localparam int COORDS = 1 << bmvs_pkg::COORD_W;
  localparam int LW     = $clog2(BRICK_EDGE);
  localparam int QW     = bmvs_pkg::COORD_W;

  // Constant quotient and remainder tables, built at elaboration.
  logic [QW-1:0] quot_tab [COORDS];
  logic [LW-1:0] rem_tab  [COORDS];

  for (genvar i = 0; i < COORDS; i++) begin : g_tab
    assign quot_tab[i] = QW'(i / BRICK_EDGE);
    assign rem_tab[i]  = LW'(i % BRICK_EDGE);
  end

  logic [QW-1:0] bx, by, bz;
  logic [LW-1:0] lx, ly, lz;

  assign bx = quot_tab[pos_x];
  assign by = quot_tab[pos_y];
  assign bz = quot_tab[pos_z];
  assign lx = rem_tab[pos_x];
  assign ly = rem_tab[pos_y];
  assign lz = rem_tab[pos_z];

  // A brick coordinate past the grid makes the whole access void.
  assign outside = (32'(bx) >= GRID_BRICKS_X) || (32'(by) >= GRID_BRICKS_Y) ||
                   (32'(bz) >= GRID_BRICKS_Z);

  // Brick order is x fastest, then z, then y.
  assign brick_idx = BI_W'(bx) + BI_W'(bz) * BI_W'(GRID_BRICKS_X) +
                     BI_W'(by) * BI_W'(GRID_BRICKS_X * GRID_BRICKS_Z);

  assign local_idx = VOX_W'(lx) + VOX_W'(lz) * VOX_W'(BRICK_EDGE) +
                     VOX_W'(ly) * VOX_W'(BRICK_EDGE * BRICK_EDGE);

endmodule

### hdl/bmvs_addr_unit.sv
// Shared pool address unit: slot base plus a stepping offset within the brick.
module bmvs_addr_unit #(
  parameter int BRICK_EDGE    = bmvs_pkg::DEF_BRICK_EDGE,
  parameter int POOL_BRICKS   = bmvs_pkg::DEF_POOL_BRICKS,
  localparam int BRICK_VOXELS = BRICK_EDGE * BRICK_EDGE * BRICK_EDGE,
  localparam int VOX_W        = $clog2(BRICK_VOXELS),
  localparam int SLOT_W       = (POOL_BRICKS > 1) ? $clog2(POOL_BRICKS) : 1,
  localparam int PA_W         = $clog2(POOL_BRICKS * BRICK_VOXELS)
) (
  input  logic                     clk,
  input  bmvs_pkg::bmvs_addr_cmd_t cmd,
  input  logic [SLOT_W-1:0]        slot,
  input  logic [VOX_W-1:0]         offset_init,
  output logic [PA_W-1:0]          addr,
  output logic [VOX_W-1:0]         offset,
  output logic                     last
);

  logic [PA_W-1:0] base;

  // Load a fresh base and offset, or step to the next voxel of the brick.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base   <= PA_W'(slot) * PA_W'(BRICK_VOXELS);
      offset <= offset_init;
    end else if (cmd.step) begin
      offset <= offset + VOX_W'(1);
    end
  end

  assign addr = base + PA_W'(offset);
  assign last = (offset == VOX_W'(BRICK_VOXELS - 1));

endmodule

### hdl/bmvs_brick_mem.sv
// Brick table memory: one port, written or read at one address a cycle.
module bmvs_brick_mem #(
  parameter int DEPTH = 4096,
  parameter int ENT_W = 17,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [ENT_W-1:0] wdata,
  output logic [ENT_W-1:0] rdata
);

  logic [ENT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### hdl/bmvs_pool_mem.sv
// Voxel pool memory: one port, registered read data that holds between reads.
module bmvs_pool_mem #(
  parameter int DEPTH = 131072,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic                        re,
  input  logic [AW-1:0]               addr,
  input  logic [bmvs_pkg::KIND_W-1:0] wdata,
  output logic [bmvs_pkg::KIND_W-1:0] rdata
);

  logic [bmvs_pkg::KIND_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### hdl/brick_map_voxel_store.sv
// Top level of the brick-map voxel store: sequencer, brick table and voxel pool.
//
//   channel  direction  payload
//   req      in         action, pos_x, pos_y, pos_z, block_kind
//   rsp      out        voxel_value, brick_was_uniform, brick_slot, pool_full
//
// A position outside the grid passes from IDLE straight to FINISH; a uniform read
// or a refused write passes through LOOKUP and DECIDE, and an access to a pointed
// brick through LOOKUP, DECIDE and POOL. A write that expands a uniform brick
// passes through FILL, where the fill loop writes one pool voxel a cycle until
// all BRICK_EDGE^3 voxels of the new slot are written. After reset a clearing pass
// writes every brick table entry, one a cycle (GRID_BRICKS_X*GRID_BRICKS_Y*
// GRID_BRICKS_Z entries, 4096 by default); req.ready stays low meanwhile. A result
// held by a stalled rsp does not block the next request, only the delivery of its result.
module brick_map_voxel_store #(
  parameter int BRICK_EDGE    = bmvs_pkg::DEF_BRICK_EDGE,
  parameter int GRID_BRICKS_X = bmvs_pkg::DEF_GRID_BRICKS_X,
  parameter int GRID_BRICKS_Y = bmvs_pkg::DEF_GRID_BRICKS_Y,
  parameter int GRID_BRICKS_Z = bmvs_pkg::DEF_GRID_BRICKS_Z,
  parameter int POOL_BRICKS   = bmvs_pkg::DEF_POOL_BRICKS
) (
  input  logic       clk,
  input  logic       rst,
  bmvs_in_if.sink    req,
  bmvs_out_if.source rsp
);

  localparam int BRICK_COUNT  = GRID_BRICKS_X * GRID_BRICKS_Y * GRID_BRICKS_Z;
  localparam int BI_W         = (BRICK_COUNT > 1) ? $clog2(BRICK_COUNT) : 1;
  localparam int BRICK_VOXELS = BRICK_EDGE * BRICK_EDGE * BRICK_EDGE;
  localparam int VOX_W        = $clog2(BRICK_VOXELS);
  localparam int SLOT_W       = (POOL_BRICKS > 1) ? $clog2(POOL_BRICKS) : 1;
  localparam int NF_W         = $clog2(POOL_BRICKS + 1);
  localparam int POOL_VOXELS  = POOL_BRICKS * BRICK_VOXELS;
  localparam int PA_W         = $clog2(POOL_VOXELS);
  localparam int KW           = bmvs_pkg::KIND_W;
  localparam int SOW          = bmvs_pkg::SLOT_OUT_W;
  localparam int ENT_W        = 1 + KW + SLOT_W;

  bmvs_pkg::bmvs_state_t state, state_next;

  // Captured request.
  logic            act_read;
  logic [KW-1:0]   kind;
  logic [BI_W-1:0] bidx;
  logic [VOX_W-1:0] lidx;

  // Result being built.
  logic            res_uniform;
  logic            res_full;
  logic            res_from_pool;
  logic [KW-1:0]   res_value;
  logic [SOW-1:0]  res_slot;

  // Output register.
  logic            out_valid;
  logic [KW-1:0]   out_value;
  logic            out_uniform;
  logic [SOW-1:0]  out_slot;
  logic            out_full;

  logic [NF_W-1:0] next_free;
  logic [BI_W-1:0] clr_cnt;

  // Decoder outputs.
  logic [BI_W-1:0]  dec_bidx;
  logic [VOX_W-1:0] dec_lidx;
  logic             dec_outside;

  // Memory and address unit connections.
  logic             brick_we, brick_re;
  logic [BI_W-1:0]  brick_addr;
  logic [ENT_W-1:0] brick_wdata, brick_rdata;
  logic             pool_we, pool_re;
  logic [KW-1:0]    pool_wdata, pool_rdata;
  logic [PA_W-1:0]  pool_addr;
  logic [VOX_W-1:0] fill_offset;
  logic             fill_last;
  bmvs_pkg::bmvs_addr_cmd_t addr_cmd;
  logic [SLOT_W-1:0] addr_slot;
  logic [VOX_W-1:0]  addr_offset_init;

  logic req_accept, out_free, out_load;
  logic ent_pointed, room, expand;
  logic [KW-1:0]     ent_type;
  logic [SLOT_W-1:0] ent_slot, new_slot;

  bmvs_coord_decode #(
    .BRICK_EDGE    (BRICK_EDGE),
    .GRID_BRICKS_X (GRID_BRICKS_X),
    .GRID_BRICKS_Y (GRID_BRICKS_Y),
    .GRID_BRICKS_Z (GRID_BRICKS_Z)
  ) u_decode (
    .pos_x     (req.pos_x),
    .pos_y     (req.pos_y),
    .pos_z     (req.pos_z),
    .brick_idx (dec_bidx),
    .local_idx (dec_lidx),
    .outside   (dec_outside)
  );

  bmvs_brick_mem #(
    .DEPTH (BRICK_COUNT),
    .ENT_W (ENT_W)
  ) u_brick_mem (
    .clk   (clk),
    .we    (brick_we),
    .re    (brick_re),
    .addr  (brick_addr),
    .wdata (brick_wdata),
    .rdata (brick_rdata)
  );

  bmvs_addr_unit #(
    .BRICK_EDGE  (BRICK_EDGE),
    .POOL_BRICKS (POOL_BRICKS)
  ) u_addr (
    .clk         (clk),
    .cmd         (addr_cmd),
    .slot        (addr_slot),
    .offset_init (addr_offset_init),
    .addr        (pool_addr),
    .offset      (fill_offset),
    .last        (fill_last)
  );

  bmvs_pool_mem #(
    .DEPTH (POOL_VOXELS)
  ) u_pool_mem (
    .clk   (clk),
    .we    (pool_we),
    .re    (pool_re),
    .addr  (pool_addr),
    .wdata (pool_wdata),
    .rdata (pool_rdata)
  );

  // Fields of the brick entry just read, and the expansion decision.
  assign ent_pointed = brick_rdata[ENT_W-1];
  assign ent_type    = brick_rdata[ENT_W-2 -: KW];
  assign ent_slot    = brick_rdata[SLOT_W-1:0];
  assign new_slot    = SLOT_W'(next_free);
  assign room        = (next_free < NF_W'(POOL_BRICKS));
  assign expand      = !act_read && !ent_pointed && room;

  assign out_free   = !out_valid || rsp.ready;
  assign req_accept = req.valid && req.ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      bmvs_pkg::ST_CLEAR: begin
        if (clr_cnt == BI_W'(BRICK_COUNT - 1)) state_next = bmvs_pkg::ST_IDLE;
      end
      bmvs_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = dec_outside ? bmvs_pkg::ST_FINISH : bmvs_pkg::ST_LOOKUP;
        end
      end
      bmvs_pkg::ST_LOOKUP: state_next = bmvs_pkg::ST_DECIDE;
      bmvs_pkg::ST_DECIDE: begin
        if (ent_pointed)  state_next = bmvs_pkg::ST_POOL;
        else if (expand)  state_next = bmvs_pkg::ST_FILL;
        else              state_next = bmvs_pkg::ST_FINISH;
      end
      bmvs_pkg::ST_POOL: state_next = bmvs_pkg::ST_FINISH;
      bmvs_pkg::ST_FILL: begin
        if (fill_last) state_next = bmvs_pkg::ST_FINISH;
      end
      bmvs_pkg::ST_FINISH: begin
        if (out_free) state_next = bmvs_pkg::ST_IDLE;
      end
      default: state_next = bmvs_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of each state.
  always_comb begin
    req.ready        = 1'b0;
    brick_we         = 1'b0;
    brick_re         = 1'b0;
    brick_addr       = bidx;
    brick_wdata      = {1'b1, ent_type, new_slot};
    pool_we          = 1'b0;
    pool_re          = 1'b0;
    pool_wdata       = kind;
    addr_cmd         = '0;
    addr_slot        = ent_pointed ? ent_slot : new_slot;
    addr_offset_init = ent_pointed ? lidx : '0;
    out_load         = 1'b0;
    case (state)
      bmvs_pkg::ST_CLEAR: begin
        brick_we    = 1'b1;
        brick_addr  = clr_cnt;
        brick_wdata = '0;
      end
      bmvs_pkg::ST_IDLE: req.ready = 1'b1;
      bmvs_pkg::ST_LOOKUP: brick_re = 1'b1;
      bmvs_pkg::ST_DECIDE: begin
        addr_cmd.load = ent_pointed || expand;
        brick_we      = expand;
      end
      bmvs_pkg::ST_POOL: begin
        pool_we = !act_read;
        pool_re = act_read;
      end
      bmvs_pkg::ST_FILL: begin
        pool_we       = 1'b1;
        pool_wdata    = (fill_offset == lidx) ? kind : ent_type;
        addr_cmd.step = 1'b1;
      end
      bmvs_pkg::ST_FINISH: out_load = out_free;
      default: ;
    endcase
  end

  // Sequencer and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bmvs_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      next_free <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bmvs_pkg::ST_CLEAR) clr_cnt <= clr_cnt + BI_W'(1);
      if (state == bmvs_pkg::ST_DECIDE && expand) next_free <= next_free + NF_W'(1);
      if (out_load)       out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // Request capture and result building.
  always_ff @(posedge clk) begin
    if (req_accept) begin
      act_read      <= (req.action == bmvs_pkg::ACT_READ);
      kind          <= req.block_kind;
      bidx          <= dec_bidx;
      lidx          <= dec_lidx;
      res_value     <= '0;
      res_uniform   <= 1'b0;
      res_slot      <= '0;
      res_full      <= 1'b0;
      res_from_pool <= 1'b0;
    end
    if (state == bmvs_pkg::ST_DECIDE) begin
      res_uniform   <= !ent_pointed;
      res_full      <= !act_read && !ent_pointed && !room;
      res_from_pool <= ent_pointed && act_read;
      res_value     <= (ent_pointed || expand) ? kind : ent_type;
      if (ent_pointed)  res_slot <= SOW'(ent_slot);
      else if (expand)  res_slot <= SOW'(new_slot);
      else              res_slot <= '0;
    end
    if (out_load) begin
      out_value   <= res_from_pool ? pool_rdata : res_value;
      out_uniform <= res_uniform;
      out_slot    <= res_slot;
      out_full    <= res_full;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.voxel_value       = out_value;
  assign rsp.brick_was_uniform = out_uniform;
  assign rsp.brick_slot        = out_slot;
  assign rsp.pool_full         = out_full;

  // A result appears only as the sequencer finishes a transaction.
  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == bmvs_pkg::ST_FINISH))
    else $error("response raised outside the finishing state");

  // Pool slots are never handed out beyond the pool.
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= NF_W'(POOL_BRICKS))
    else $error("free slot count beyond pool size");

  // The free slot count moves only when a brick is expanded.
  a_slot_on_expand: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && next_free != $past(next_free)) |->
      $past(state == bmvs_pkg::ST_DECIDE && expand))
    else $error("free slot count changed without an expansion");

  // A new request is never taken, and the pool is written, while a fill is in progress.
  a_no_accept_in_fill: assert property (@(posedge clk) disable iff (rst)
    (state == bmvs_pkg::ST_FILL) |-> !req_accept && pool_we)
    else $error("request accepted during a brick fill");

endmodule
